### src/prq_pkg.sv
package prq_pkg;

    localparam int LEVELS     = 8;
    localparam int TASKS      = 16;
    localparam int DEPTH      = 16;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int ID_W       = $clog2(TASKS);
    localparam int POS_W      = $clog2(DEPTH);
    localparam int FILL_W     = POS_W + 1;
    localparam int ADDR_W     = LVL_W + POS_W;
    localparam int SLICE_W    = 16;
    localparam int SW_W       = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SET    = 3'd2,
        CMD_PICK   = 3'd3,
        CMD_TICK   = 3'd4,
        CMD_START  = 3'd5,
        CMD_STOP   = 3'd6,
        CMD_NONE   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOTASK = 2'd3
    } t_status;

    localparam logic [1:0] FLAG_BLOCKED = 2'd0;
    localparam logic [1:0] FLAG_READY   = 2'd1;
    localparam logic [1:0] FLAG_RUNNING = 2'd2;

endpackage

### src/prq_slot_ram.sv
module prq_slot_ram
    import prq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ID_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ID_W-1:0]   o_rdata
);

    logic [ID_W-1:0] r_mem [LEVELS*DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/priority_ready_queue_scheduler.sv
// Ready-list scheduler with one ring queue of task ids per priority level,
// kept in a single slot memory with one write and one registered read port.
// One command is taken at a time and its result is held in an output register
// until it is taken; the input is not ready until then. Add and set ready flag
// pass through their own state and then the finish register before the result
// shows, and stop, a tick while stopped and the unused code go straight to the
// finish register. Pick, tick and start walk the levels from highest to lowest,
// reading the head of each non-empty level from the slot memory. Remove compares
// one queue slot at a time and then closes the gap one slot at a time, each step
// waiting on the registered read port of the slot memory.
module priority_ready_queue_scheduler
    import prq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: task_id[3:0], task_priority[6:4], task_slice[22:7], ready_flag[23].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[2:0].
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: status[1:0], chosen_id[5:2], prev_valid[6], prev_id[10:7],
    // slice_loaded[26:11], switch_count[58:27], is_running[59], zeros above.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_ADD     = 10'b0000000010,
        S_SET     = 10'b0000000100,
        S_RM_RD   = 10'b0000001000,
        S_RM_CMP  = 10'b0000010000,
        S_SH_RD   = 10'b0000100000,
        S_SH_WR   = 10'b0001000000,
        S_SC_CHK  = 10'b0010000000,
        S_SC_DATA = 10'b0100000000,
        S_TK_PREV = 10'b1000000000
    } t_state;

    t_state r_state;
    logic   r_disp;
    logic   r_fin;

    t_cmd                r_cmd;
    logic [ID_W-1:0]     r_id;
    logic [LVL_W-1:0]    r_pri;
    logic [SLICE_W-1:0]  r_slice_in;
    logic                r_rdy_in;

    logic [POS_W-1:0]    r_head   [LEVELS];
    logic [FILL_W-1:0]   r_fill   [LEVELS];
    logic [LVL_W-1:0]    r_level  [TASKS];
    logic [1:0]          r_flags  [TASKS];
    logic [SLICE_W-1:0]  r_slices [TASKS];

    logic [ID_W-1:0]     r_cur;
    logic                r_cur_v;
    logic                r_run;
    logic [SW_W-1:0]     r_sw;
    logic [SLICE_W-1:0]  r_slice_left;
    logic [LVL_W-1:0]    r_lvl;
    logic [FILL_W-1:0]   r_pos;
    logic [ID_W-1:0]     r_next;

    t_status             r_status;
    logic [ID_W-1:0]     r_chosen;
    logic                r_pv;
    logic [ID_W-1:0]     r_pid;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic                accept;
    logic [LVL_W-1:0]    q_idx;
    logic [POS_W-1:0]    q_head;
    logic [FILL_W-1:0]   q_fill;
    logic [POS_W-1:0]    q_tail;
    logic [ID_W-1:0]     flag_idx;
    logic [1:0]          flag_rd;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ID_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ID_W-1:0]     ram_rdata;
    logic [FILL_W-1:0]   pos_inc;
    logic                slice_en;

    assign s_axis_tready = (r_state == S_IDLE) && !r_disp && !r_fin && !r_out_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign slice_en      = (r_status == ST_DONE) && (r_cmd == CMD_TICK || r_cmd == CMD_START);

    always_comb begin
        if (r_state == S_TK_PREV) begin
            q_idx = r_level[r_cur];
        end else if (r_state == S_SC_CHK || r_state == S_SC_DATA) begin
            q_idx = r_lvl;
        end else begin
            q_idx = r_pri;
        end
    end

    assign q_head   = r_head[q_idx];
    assign q_fill   = r_fill[q_idx];
    assign q_tail   = q_head + q_fill[POS_W-1:0];
    assign flag_idx = (r_state == S_SC_DATA) ? ram_rdata : r_cur;
    assign flag_rd  = r_flags[flag_idx];
    assign pos_inc  = r_pos + FILL_W'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {q_idx, q_tail};
        ram_wdata = r_id;
        ram_raddr = {q_idx, q_head};
        unique case (r_state)
            S_ADD: begin
                ram_we = !q_fill[POS_W];
            end
            S_RM_RD: begin
                ram_raddr = {q_idx, q_head + r_pos[POS_W-1:0]};
            end
            S_SH_RD: begin
                ram_raddr = {q_idx, q_head + pos_inc[POS_W-1:0]};
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {q_idx, q_head + r_pos[POS_W-1:0]};
                ram_wdata = ram_rdata;
            end
            S_SC_DATA: begin
                ram_we    = (flag_rd != FLAG_READY);
                ram_wdata = ram_rdata;
            end
            S_TK_PREV: begin
                ram_we    = r_cur_v && (flag_rd == FLAG_RUNNING) && !q_fill[POS_W];
                ram_wdata = r_cur;
            end
            default: begin
            end
        endcase
    end

    prq_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_disp       <= 1'b0;
            r_fin        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cur        <= '0;
            r_cur_v      <= 1'b0;
            r_run        <= 1'b0;
            r_sw         <= '0;
            r_slice_left <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
            for (int i = 0; i < TASKS; i++) begin
                r_flags[i] <= FLAG_BLOCKED;
            end
        end else begin
            r_fin <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_fin) begin
                r_out_valid <= 1'b1;
                r_out <= {4'b0, r_run, r_sw, r_slice_left & {SLICE_W{slice_en}},
                          r_pid, r_pv, r_chosen, r_status};
            end
            if (r_disp) begin
                r_disp              <= 1'b0;
                r_cur               <= r_next;
                r_cur_v             <= 1'b1;
                r_flags[r_next]     <= FLAG_RUNNING;
                r_slice_left        <= r_slices[r_next];
                r_sw                <= r_sw + SW_W'(1);
                r_chosen            <= r_next;
                r_status            <= ST_DONE;
                r_fin               <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= t_cmd'(s_axis_tuser);
                        r_id       <= s_axis_tdata[3:0];
                        r_pri      <= s_axis_tdata[6:4];
                        r_slice_in <= s_axis_tdata[22:7];
                        r_rdy_in   <= s_axis_tdata[23];
                        r_status   <= ST_DONE;
                        r_chosen   <= '0;
                        r_pv       <= 1'b0;
                        r_pid      <= '0;
                        r_pos      <= '0;
                        r_lvl      <= LVL_W'(LEVELS - 1);
                        unique case (t_cmd'(s_axis_tuser))
                            CMD_ADD:    r_state <= S_ADD;
                            CMD_REMOVE: r_state <= S_RM_RD;
                            CMD_SET:    r_state <= S_SET;
                            CMD_PICK:   r_state <= S_SC_CHK;
                            CMD_TICK: begin
                                if (r_run) begin
                                    r_state <= S_SC_CHK;
                                end else begin
                                    r_status <= ST_NOTASK;
                                    r_fin    <= 1'b1;
                                end
                            end
                            CMD_START: begin
                                r_run   <= 1'b1;
                                r_state <= S_SC_CHK;
                            end
                            CMD_STOP: begin
                                r_run <= 1'b0;
                                r_fin <= 1'b1;
                            end
                            default: begin
                                r_fin <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if (q_fill[POS_W]) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_level[r_id]  <= r_pri;
                        r_slices[r_id] <= r_slice_in;
                        r_fill[q_idx]  <= q_fill + FILL_W'(1);
                    end
                    r_fin   <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SET: begin
                    r_flags[r_id] <= r_rdy_in ? FLAG_READY : FLAG_BLOCKED;
                    r_fin         <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_RM_RD: begin
                    if (r_pos == q_fill) begin
                        r_status <= ST_NOTASK;
                        r_fin    <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_RM_CMP;
                    end
                end
                S_RM_CMP: begin
                    if (ram_rdata == r_id) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_pos   <= pos_inc;
                        r_state <= S_RM_RD;
                    end
                end
                S_SH_RD: begin
                    if (pos_inc >= q_fill) begin
                        r_fill[q_idx] <= q_fill - FILL_W'(1);
                        r_fin         <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_pos   <= pos_inc;
                    r_state <= S_SH_RD;
                end
                S_SC_CHK: begin
                    if (q_fill != '0) begin
                        r_state <= S_SC_DATA;
                    end else if (r_lvl == '0) begin
                        r_status <= ST_NOTASK;
                        r_fin    <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_lvl <= r_lvl - LVL_W'(1);
                    end
                end
                S_SC_DATA: begin
                    r_head[q_idx] <= q_head + POS_W'(1);
                    if (flag_rd == FLAG_READY) begin
                        r_fill[q_idx] <= q_fill - FILL_W'(1);
                        r_next        <= ram_rdata;
                        if (r_cmd == CMD_PICK) begin
                            r_chosen <= ram_rdata;
                            r_fin    <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_TK_PREV;
                        end
                    end else if (r_lvl == '0) begin
                        r_status <= ST_NOTASK;
                        r_fin    <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_lvl   <= r_lvl - LVL_W'(1);
                        r_state <= S_SC_CHK;
                    end
                end
                S_TK_PREV: begin
                    r_pv  <= r_cur_v;
                    r_pid <= r_cur_v ? r_cur : '0;
                    if (r_cur_v && flag_rd == FLAG_RUNNING) begin
                        r_flags[r_cur] <= FLAG_READY;
                        if (!q_fill[POS_W]) begin
                            r_fill[q_idx] <= q_fill + FILL_W'(1);
                        end
                    end
                    r_disp  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("ready right after an accepted beat");

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> m_axis_tvalid)
        else $error("finished command did not present a result");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_CHK) |-> (q_fill <= FILL_W'(DEPTH)))
        else $error("queue fill beyond depth");

endmodule
